/* rtl/core/csh_pkg.sv */
package csh_pkg;

  localparam int MaxCols   = 256;
  localparam int MaxRows   = 256;
  localparam int Pixels    = MaxCols * MaxRows;
  localparam int AddrW     = $clog2(Pixels);

  // angle bin edges, Q2.13
  localparam logic signed [16:0] PiQ13  = 17'sd25736;
  localparam logic signed [16:0] BinT1  = 17'sd3217;
  localparam logic signed [16:0] BinT2  = 17'sd9651;
  localparam logic signed [16:0] BinT3  = 17'sd16085;
  localparam logic signed [16:0] BinT4  = 17'sd22519;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_READ = 2'd2
  } mode_t;

  localparam logic [1:0] CFG_LOW    = 2'd0;
  localparam logic [1:0] CFG_HIGH   = 2'd1;
  localparam logic [1:0] CFG_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_HEIGHT = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic [AddrW-1:0] mag_addr;
    logic             mag_we;
    logic [15:0]      mag_wdata;
    logic [1:0]       dir_wdata;
    logic [AddrW-1:0] sup_addr;
    logic             sup_we;
    logic             sup_from_center;
    logic [AddrW-1:0] edge_addr;
    logic             edge_we;
    logic             edge_wdata;
    logic [AddrW-1:0] stk_addr;
    logic             stk_we;
    logic [AddrW-1:0] stk_wdata;
    logic             cap_center;
    logic             cap_a;
    logic [15:0]      low_thr;
    logic [15:0]      high_thr;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0]       dir_rdata;
    logic             keep;
    logic             sup_ge_high;
    logic             sup_gt_low;
    logic             edge_rdata;
    logic [AddrW-1:0] stk_rdata;
  } status_t;

  // quantize gradient angle into one of four directions
  function automatic logic [1:0] bin_angle(input logic signed [15:0] ang);
    logic signed [16:0] a;
    begin
      a = 17'(ang);
      if (a < 0) a = a + PiQ13;
      if (a < BinT1 || a >= BinT4) bin_angle = 2'd0;
      else if (a < BinT2)          bin_angle = 2'd1;
      else if (a < BinT3)          bin_angle = 2'd2;
      else                         bin_angle = 2'd3;
    end
  endfunction

  // row/col deltas of the two compare neighbors, {dr_a, dc_a, dr_b, dc_b}
  function automatic logic [7:0] dir_offsets(input logic [1:0] d);
    begin
      case (d)
        2'd0:    dir_offsets = {2'b00, 2'b11, 2'b00, 2'b01};
        2'd1:    dir_offsets = {2'b11, 2'b11, 2'b01, 2'b01};
        2'd2:    dir_offsets = {2'b11, 2'b00, 2'b01, 2'b00};
        default: dir_offsets = {2'b11, 2'b01, 2'b01, 2'b11};
      endcase
    end
  endfunction

  // 8-neighborhood deltas, {dr, dc}
  function automatic logic [3:0] nb_offset(input logic [2:0] k);
    begin
      case (k)
        3'd0:    nb_offset = {2'b11, 2'b11};
        3'd1:    nb_offset = {2'b11, 2'b00};
        3'd2:    nb_offset = {2'b11, 2'b01};
        3'd3:    nb_offset = {2'b00, 2'b11};
        3'd4:    nb_offset = {2'b00, 2'b01};
        3'd5:    nb_offset = {2'b01, 2'b11};
        3'd6:    nb_offset = {2'b01, 2'b00};
        default: nb_offset = {2'b01, 2'b01};
      endcase
    end
  endfunction

endpackage

/* rtl/core/csh_ram.sv */
module csh_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/csh_datapath.sv */
module csh_datapath
  import csh_pkg::*;
(
  input  logic    clk,
  input  cmd_t    cmd,
  output status_t status
);

  logic [15:0]      mag_rdata;
  logic [1:0]       dir_rdata;
  logic [15:0]      sup_rdata;
  logic             edge_rdata;
  logic [AddrW-1:0] stk_rdata;
  logic [15:0]      m_center;
  logic [15:0]      m_a;

  csh_ram #(.Width(16), .Depth(Pixels)) u_mag (
    .clk(clk), .we(cmd.mag_we), .addr(cmd.mag_addr),
    .wdata(cmd.mag_wdata), .rdata(mag_rdata)
  );

  csh_ram #(.Width(2), .Depth(Pixels)) u_dir (
    .clk(clk), .we(cmd.mag_we), .addr(cmd.mag_addr),
    .wdata(cmd.dir_wdata), .rdata(dir_rdata)
  );

  csh_ram #(.Width(16), .Depth(Pixels)) u_sup (
    .clk(clk), .we(cmd.sup_we), .addr(cmd.sup_addr),
    .wdata(cmd.sup_from_center ? m_center : 16'd0), .rdata(sup_rdata)
  );

  csh_ram #(.Width(1), .Depth(Pixels)) u_edge (
    .clk(clk), .we(cmd.edge_we), .addr(cmd.edge_addr),
    .wdata(cmd.edge_wdata), .rdata(edge_rdata)
  );

  csh_ram #(.Width(AddrW), .Depth(Pixels)) u_stk (
    .clk(clk), .we(cmd.stk_we), .addr(cmd.stk_addr),
    .wdata(cmd.stk_wdata), .rdata(stk_rdata)
  );

  // center and first neighbor magnitudes for suppression
  always_ff @(posedge clk) begin
    if (cmd.cap_center) m_center <= mag_rdata;
    if (cmd.cap_a)      m_a      <= mag_rdata;
  end

  assign status.dir_rdata   = dir_rdata;
  assign status.keep        = (m_center > m_a) && (m_center > mag_rdata);
  assign status.sup_ge_high = sup_rdata >= cmd.high_thr;
  assign status.sup_gt_low  = sup_rdata > cmd.low_thr;
  assign status.edge_rdata  = edge_rdata;
  assign status.stk_rdata   = stk_rdata;

endmodule

/* rtl/core/csh_ctrl.sv */
module csh_ctrl
  import csh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output cmd_t        cmd,
  input  status_t     status
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_RD, S_RESP,
    S_N0, S_N1, S_N2, S_N3,
    S_H0, S_H1, S_ADV,
    S_T0, S_T1, S_T2, S_T3
  } state_t;

  state_t      state;
  logic [15:0] low_thr, high_thr;
  logic [8:0]  img_w, img_h;
  logic [AddrW-1:0] clr_cnt;
  logic        clr_run;
  logic [7:0]  r, c, tr, tc;
  logic [1:0]  dir_q;
  logic [2:0]  nb;
  logic [AddrW:0] sp;
  logic        res_edge, res_done;

  // input word fields
  logic [1:0]  in_mode;
  logic [7:0]  in_row, in_col;
  logic [15:0] in_mag;
  logic [15:0] in_ang;
  assign in_mode = s_tdata[1:0];
  assign in_row  = s_tdata[9:2];
  assign in_col  = s_tdata[17:10];
  assign in_mag  = s_tdata[33:18];
  assign in_ang  = s_tdata[49:34];

  logic accept;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // result goes out when the output register is free or being emptied
  logic resp_fire;
  assign resp_fire = (state == S_RESP) && (!m_tvalid || m_tready);

  // dimensions saturated to the store size
  logic [8:0] w_sat, h_sat;
  assign w_sat = (img_w > 9'(MaxCols)) ? 9'(MaxCols) : img_w;
  assign h_sat = (img_h > 9'(MaxRows)) ? 9'(MaxRows) : img_h;

  logic small_img, last_col, last_row;
  assign small_img = (w_sat < 9'd3) || (h_sat < 9'd3);
  assign last_col  = ({1'b0, c} + 9'd2) >= w_sat;
  assign last_row  = ({1'b0, r} + 9'd2) >= h_sat;

  // suppression neighbor addresses
  logic [7:0] offs_live, offs_q;
  logic [7:0] ar_live, ac_live, br, bc;
  assign offs_live = dir_offsets(status.dir_rdata);
  assign offs_q    = dir_offsets(dir_q);
  assign ar_live   = r + {{6{offs_live[7]}}, offs_live[7:6]};
  assign ac_live   = c + {{6{offs_live[5]}}, offs_live[5:4]};
  assign br        = r + {{6{offs_q[3]}}, offs_q[3:2]};
  assign bc        = c + {{6{offs_q[1]}}, offs_q[1:0]};

  // trace neighbor address and bounds
  logic [3:0] nbo;
  logic [9:0] ny, nx;
  logic       nb_ok;
  assign nbo   = nb_offset(nb);
  assign ny    = {2'b00, tr} + {{8{nbo[3]}}, nbo[3:2]};
  assign nx    = {2'b00, tc} + {{8{nbo[1]}}, nbo[1:0]};
  assign nb_ok = !ny[9] && (ny[8:0] < h_sat) && !nx[9] && (nx[8:0] < w_sat);

  logic [AddrW-1:0] sp_m1;
  logic [AddrW:0]   sp_dec;
  assign sp_dec = sp - 1'b1;
  assign sp_m1  = sp_dec[AddrW-1:0];

  logic push_seed, push_nb;
  assign push_seed = status.sup_ge_high && !status.edge_rdata;
  assign push_nb   = status.sup_gt_low && !status.edge_rdata;

  // datapath commands
  always_comb begin
    cmd                 = '0;
    cmd.low_thr         = low_thr;
    cmd.high_thr        = high_thr;
    cmd.mag_addr        = {r, c};
    cmd.sup_addr        = {r, c};
    cmd.edge_addr       = {r, c};
    cmd.stk_addr        = sp[AddrW-1:0];
    cmd.stk_wdata       = {r, c};
    cmd.edge_wdata      = 1'b1;
    unique case (state)
      S_IDLE: begin
        cmd.mag_addr  = {in_row, in_col};
        cmd.edge_addr = {in_row, in_col};
        cmd.mag_wdata = in_mag;
        cmd.dir_wdata = bin_angle(in_ang);
        cmd.mag_we    = accept && (in_mode == MODE_LOAD);
      end
      S_CLR: begin
        cmd.sup_addr   = clr_cnt;
        cmd.edge_addr  = clr_cnt;
        cmd.sup_we     = 1'b1;
        cmd.edge_we    = 1'b1;
        cmd.edge_wdata = 1'b0;
      end
      S_N1: begin
        cmd.cap_center = 1'b1;
        cmd.mag_addr   = {ar_live, ac_live};
      end
      S_N2: begin
        cmd.cap_a    = 1'b1;
        cmd.mag_addr = {br, bc};
      end
      S_N3: begin
        cmd.sup_we          = status.keep;
        cmd.sup_from_center = 1'b1;
      end
      S_H1: begin
        cmd.edge_we = push_seed;
        cmd.stk_we  = push_seed;
      end
      S_T0: cmd.stk_addr = sp_m1;
      S_T2: begin
        cmd.sup_addr  = {ny[7:0], nx[7:0]};
        cmd.edge_addr = {ny[7:0], nx[7:0]};
      end
      S_T3: begin
        cmd.edge_addr = {ny[7:0], nx[7:0]};
        cmd.stk_wdata = {ny[7:0], nx[7:0]};
        cmd.edge_we   = push_nb;
        cmd.stk_we    = push_nb;
      end
      default: ;
    endcase
  end

  // state, counters, config and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_cnt  <= '0;
      clr_run  <= 1'b0;
      sp       <= '0;
      m_tvalid <= 1'b0;
      low_thr  <= 16'd0;
      high_thr <= 16'd0;
      img_w    <= 9'd256;
      img_h    <= 9'd256;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOW:    low_thr  <= cfg_wdata;
          CFG_HIGH:   high_thr <= cfg_wdata;
          CFG_WIDTH:  img_w    <= cfg_wdata[8:0];
          CFG_HEIGHT: img_h    <= cfg_wdata[8:0];
          default: ;
        endcase
      end

      // output word handshake
      if (resp_fire) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_edge <= 1'b0;
            res_done <= 1'b0;
            case (in_mode)
              MODE_RUN: begin
                clr_cnt <= '0;
                clr_run <= 1'b1;
                sp      <= '0;
                state   <= S_CLR;
              end
              MODE_READ: state <= S_RD;
              default:   state <= S_RESP;
            endcase
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (&clr_cnt) begin
            r <= 8'd1;
            c <= 8'd1;
            if (!clr_run) state <= S_IDLE;
            else if (small_img) begin
              res_done <= 1'b1;
              state    <= S_RESP;
            end else state <= S_N0;
          end
        end
        S_RD: begin
          res_edge <= status.edge_rdata;
          state    <= S_RESP;
        end
        S_RESP: begin
          if (resp_fire) begin
            m_tdata  <= {6'd0, res_done, res_edge};
            clr_run  <= 1'b0;
            state    <= S_IDLE;
          end
        end
        S_N0: state <= S_N1;
        S_N1: begin
          dir_q <= status.dir_rdata;
          state <= S_N2;
        end
        S_N2: state <= S_N3;
        S_N3: begin
          if (!last_col) begin
            c     <= c + 8'd1;
            state <= S_N0;
          end else begin
            c <= 8'd1;
            if (!last_row) begin
              r     <= r + 8'd1;
              state <= S_N0;
            end else begin
              r     <= 8'd1;
              state <= S_H0;
            end
          end
        end
        S_H0: state <= S_H1;
        S_H1: begin
          if (push_seed) begin
            sp    <= sp + 1'b1;
            state <= S_T0;
          end else state <= S_ADV;
        end
        S_ADV: begin
          if (!last_col) begin
            c     <= c + 8'd1;
            state <= S_H0;
          end else begin
            c <= 8'd1;
            if (!last_row) begin
              r     <= r + 8'd1;
              state <= S_H0;
            end else begin
              res_done <= 1'b1;
              state    <= S_RESP;
            end
          end
        end
        S_T0: begin
          if (sp == '0) state <= S_ADV;
          else begin
            sp    <= sp_dec;
            state <= S_T1;
          end
        end
        S_T1: begin
          tr    <= status.stk_rdata[AddrW-1:8];
          tc    <= status.stk_rdata[7:0];
          nb    <= 3'd0;
          state <= S_T2;
        end
        S_T2: begin
          if (nb_ok) state <= S_T3;
          else if (nb == 3'd7) state <= S_T0;
          else nb <= nb + 3'd1;
        end
        S_T3: begin
          if (push_nb) sp <= sp + 1'b1;
          if (nb == 3'd7) state <= S_T0;
          else begin
            nb    <= nb + 3'd1;
            state <= S_T2;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // stack depth never exceeds the pixel count
  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= (AddrW+1)'(Pixels))
    else $error("trace stack overflow");

  // every push marks the pixel it stacks
  a_push_marks: assert property (@(posedge clk) disable iff (rst)
    cmd.stk_we |-> (cmd.edge_we && cmd.edge_wdata))
    else $error("push without edge mark");

  // gradient store only written from an accepted load
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mag_we |-> (state == S_IDLE && accept))
    else $error("gradient write outside a load");

  // a result word never carries both flags
  a_res_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("run_done and edge_marked both set");

endmodule

/* rtl/core/canny_suppress_and_hysteresis.sv */
// Canny back end: non-maximum suppression and hysteresis edge tracing.
// Input stream (s_*): one word per command. mode 0 loads one pixel's
// gradient magnitude and angle, mode 1 runs detection over the image set by
// image_width/image_height, mode 2 reads back one pixel's edge mark.
// Output stream (m_*): exactly one word per input word, in order.
// Config port: cfg_we/cfg_index/cfg_wdata, to be written only while idle (the block does not enforce this).
// A read fetches the pixel's edge mark before it answers. A run first
// clears the suppressed and edge stores (65536 entries, one entry per
// cycle), then runs suppression over every interior pixel, then scans
// the interior pixels for seeds and traces each seed through its in-image
// neighbors with a stack.
// Each step is paced by the single-port gradient, suppressed and edge memories.
// One word is handled at a time; s_tready is high only while idle, and a
// finished word is accepted even while the previous result waits.
// Reset: registers go to 0, 0, 256, 256 and the edge/suppressed stores are
// swept to zero, all 65536 entries, with s_tready low.
// A stalled receiver holds the answer in the output register; a following
// answer waits for it to be taken before the block returns to idle.
module canny_suppress_and_hysteresis
  import csh_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // mode[1:0], pixel_row, pixel_col, grad_magnitude, grad_angle
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // edge_marked, run_done
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  csh_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .cmd(cmd), .status(status)
  );

  csh_datapath u_dp (
    .clk(clk), .cmd(cmd), .status(status)
  );

endmodule
